// File: src/tomzc_pkg.sv
// Package for the TCP option MSS zero check block.
// Holds the word types, the parse state type and the phase, class and cause codes.
// Standalone: depends on nothing else.
package tomzc_pkg;

  // Parse phases.
  localparam logic [2:0] PH_KIND   = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_SKIP   = 3'd2;
  localparam logic [2:0] PH_MSS_HI = 3'd3;
  localparam logic [2:0] PH_MSS_LO = 3'd4;

  // Option kind classes.
  localparam logic [1:0] CLS_OTHER = 2'd0;
  localparam logic [1:0] CLS_WS    = 2'd1;
  localparam logic [1:0] CLS_MSS   = 2'd2;

  // End causes; a nonzero stop code uses the same values.
  localparam logic [2:0] CAUSE_EXHAUSTED = 3'd0;
  localparam logic [2:0] CAUSE_END       = 3'd1;
  localparam logic [2:0] CAUSE_ZERO_LEN  = 3'd2;
  localparam logic [2:0] CAUSE_MSS_READ  = 3'd3;
  localparam logic [2:0] CAUSE_MSS_TRUNC = 3'd4;

  // Option kinds and lengths of interest.
  localparam logic [7:0] KIND_END = 8'd0;
  localparam logic [7:0] KIND_NOP = 8'd1;
  localparam logic [7:0] KIND_MSS = 8'd2;
  localparam logic [7:0] KIND_WS  = 8'd3;
  localparam logic [7:0] LEN_WS   = 8'd3;
  localparam logic [7:0] LEN_MSS  = 8'd4;

  typedef struct packed {
    logic [7:0] option_byte;
    logic       first_of_area;
    logic       last_of_area;
  } in_word_t;

  typedef struct packed {
    logic       mss_zero;
    logic [2:0] end_cause;
  } out_word_t;

  typedef struct packed {
    logic [2:0] parse_phase;
    logic [1:0] kind_class;
    logic [7:0] skip_count;
    logic [7:0] mss_high_byte;
    logic [2:0] stop_code;
    logic       zero_mss_flag;
  } parse_state_t;

  localparam parse_state_t STATE_INIT = '0;

endpackage

// File: src/tomzc_step.sv
// One parse step: next parse state and verdict for one options byte.
// Depends on tomzc_pkg.
module tomzc_step (
  input  tomzc_pkg::parse_state_t cur,
  input  tomzc_pkg::in_word_t     word,
  output tomzc_pkg::parse_state_t nxt,
  output tomzc_pkg::out_word_t    verdict
);
  import tomzc_pkg::*;

  parse_state_t base;
  parse_state_t walked;
  logic [7:0]   b;

  assign b = word.option_byte;

  always_comb begin
    base   = word.first_of_area ? STATE_INIT : cur;
    walked = base;
    if (base.stop_code == CAUSE_EXHAUSTED) begin
      unique case (base.parse_phase)
        PH_KIND: begin
          if (b == KIND_END) begin
            walked.stop_code = CAUSE_END;
          end else if (b != KIND_NOP) begin
            walked.kind_class  = (b == KIND_WS) ? CLS_WS :
                                 (b == KIND_MSS) ? CLS_MSS : CLS_OTHER;
            walked.parse_phase = PH_LEN;
          end
        end
        PH_LEN: begin
          if (base.kind_class == CLS_WS && b == LEN_WS) begin
            walked.skip_count  = 8'd1;
            walked.parse_phase = PH_SKIP;
          end else if (base.kind_class == CLS_MSS && b == LEN_MSS) begin
            walked.parse_phase = PH_MSS_HI;
          end else if (b == 8'd0) begin
            walked.stop_code = CAUSE_ZERO_LEN;
          end else if (b <= 8'd2) begin
            walked.parse_phase = PH_KIND;
          end else begin
            walked.skip_count  = b - 8'd2;
            walked.parse_phase = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (base.skip_count <= 8'd1) begin
            walked.skip_count  = 8'd0;
            walked.parse_phase = PH_KIND;
          end else begin
            walked.skip_count = base.skip_count - 8'd1;
          end
        end
        PH_MSS_HI: begin
          walked.mss_high_byte = b;
          walked.parse_phase   = PH_MSS_LO;
        end
        PH_MSS_LO: begin
          walked.zero_mss_flag = (base.mss_high_byte == 8'd0) && (b == 8'd0);
          walked.stop_code     = CAUSE_MSS_READ;
        end
        default: begin
          walked.parse_phase = PH_KIND;
        end
      endcase
    end

    // Verdict; only used when the byte closes the area.
    if (walked.stop_code != CAUSE_EXHAUSTED) begin
      verdict.end_cause = walked.stop_code;
    end else if (walked.parse_phase == PH_MSS_HI || walked.parse_phase == PH_MSS_LO) begin
      verdict.end_cause = CAUSE_MSS_TRUNC;
    end else begin
      verdict.end_cause = CAUSE_EXHAUSTED;
    end
    verdict.mss_zero = (verdict.end_cause == CAUSE_MSS_READ) && walked.zero_mss_flag;

    // Drop back to the initial state after a verdict.
    nxt = word.last_of_area ? STATE_INIT : walked;
  end

endmodule

// File: src/tcp_option_mss_zero_check_unit.sv
// Top level of the TCP option MSS zero check block.
// Depends on tomzc_pkg and tomzc_step.
//
//   channel   signals                          carries
//   --------  -------------------------------  ------------------------------------
//   in        in_valid, in_ready, in_data      one options byte plus area marks
//   out       out_valid, out_ready, out_data   mss_zero flag and end cause, per area
//
// One byte enters per cycle unless a closing byte waits for the output slot. A byte is held
// in the input register, walked through the single parse step and, if it closes the area,
// its verdict is loaded into the output register once the output slot is free.
// rst (synchronous) clears both valid bits and the parse state.
// A stalled out channel holds the verdict; the input register still advances bytes
// that do not close an area, and only a second verdict waits for the slot to free.
module tcp_option_mss_zero_check_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tomzc_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tomzc_pkg::out_word_t out_data
);
  import tomzc_pkg::*;

  logic         hold_valid;
  in_word_t     hold_word;
  parse_state_t state;
  parse_state_t state_next;
  out_word_t    verdict;
  logic         advance;
  logic         slot_free;

  // Walk the held byte against the current parse state.
  tomzc_step u_step (
    .cur     (state),
    .word    (hold_word),
    .nxt     (state_next),
    .verdict (verdict)
  );

  // A closing byte needs the output slot; any other byte moves on at once.
  assign slot_free = !out_valid || out_ready;
  assign advance   = hold_valid && (!hold_word.last_of_area || slot_free);
  assign in_ready  = !hold_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      hold_word <= in_data;
    end
  end

  // Parse state: advance once per walked byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_INIT;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && hold_word.last_of_area) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && hold_word.last_of_area) begin
      out_data <= verdict;
    end
  end

  // The flag is set only on a completed MSS read.
  a_flag_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.mss_zero |-> out_data.end_cause == CAUSE_MSS_READ)
    else $error("mss_zero set with end cause other than MSS read");

  // No cause beyond MSS truncated is ever reported.
  a_cause_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.end_cause <= CAUSE_MSS_TRUNC)
    else $error("end cause out of range");

  // A verdict returns the parser to its initial state.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    advance && hold_word.last_of_area |=> state == STATE_INIT && out_valid)
    else $error("parser not restarted after verdict");

  // A waiting verdict is never overwritten.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(advance && hold_word.last_of_area))
    else $error("verdict overwritten while waiting");

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// Testbench for tcp_option_mss_zero_check_unit: walks TCP options areas byte by byte
// and checks each per-area verdict against an in-bench option walker.
// Depends on tomzc_pkg and the RTL of the unit; nothing else.

module testbench;
  import tomzc_pkg::*;

  // Option walker plus the queue of verdicts it says are due, oldest first.
  class area_verdict_board;
    parse_state_t walk = STATE_INIT;
    out_word_t    due_verdicts[$];
    int           errors = 0;
    int           bytes_taken = 0;
    int           verdicts_seen = 0;
    int           zero_mss_seen = 0;
    int           cause_hits[5] = '{0, 0, 0, 0, 0};

    // Advance the walk by one accepted word; queue a verdict when it closes an area.
    function void note_word(in_word_t w);
      logic [7:0] b;
      out_word_t  v;
      b = w.option_byte;
      bytes_taken++;
      if (w.first_of_area) walk = STATE_INIT;
      // A zero stop code means the walk is still live; after a stop, drop bytes.
      if (walk.stop_code == CAUSE_EXHAUSTED) begin
        case (walk.parse_phase)
          PH_KIND: begin
            if (b == KIND_END) begin
              walk.stop_code = CAUSE_END;
            end else if (b != KIND_NOP) begin
              walk.kind_class = (b == KIND_WS) ? CLS_WS :
                                (b == KIND_MSS) ? CLS_MSS : CLS_OTHER;
              walk.parse_phase = PH_LEN;
            end
          end
          PH_LEN: begin
            if (walk.kind_class == CLS_WS && b == LEN_WS) begin
              walk.skip_count = 8'd1;
              walk.parse_phase = PH_SKIP;
            end else if (walk.kind_class == CLS_MSS && b == LEN_MSS) begin
              walk.parse_phase = PH_MSS_HI;
            end else if (b == 8'd0) begin
              walk.stop_code = CAUSE_ZERO_LEN;
            end else if (b <= 8'd2) begin
              // length one or two: no body, next byte is a kind
              walk.parse_phase = PH_KIND;
            end else begin
              walk.skip_count = b - 8'd2;
              walk.parse_phase = PH_SKIP;
            end
          end
          PH_SKIP: begin
            if (walk.skip_count <= 8'd1) begin
              walk.skip_count = 8'd0;
              walk.parse_phase = PH_KIND;
            end else begin
              walk.skip_count = walk.skip_count - 8'd1;
            end
          end
          PH_MSS_HI: begin
            walk.mss_high_byte = b;
            walk.parse_phase = PH_MSS_LO;
          end
          PH_MSS_LO: begin
            walk.zero_mss_flag = ({walk.mss_high_byte, b} == 16'd0);
            walk.stop_code = CAUSE_MSS_READ;
          end
          default: walk.parse_phase = PH_KIND;
        endcase
      end
      if (w.last_of_area) begin
        if (walk.stop_code != CAUSE_EXHAUSTED)
          v.end_cause = walk.stop_code;
        else if (walk.parse_phase == PH_MSS_HI || walk.parse_phase == PH_MSS_LO)
          v.end_cause = CAUSE_MSS_TRUNC;
        else
          v.end_cause = CAUSE_EXHAUSTED;
        v.mss_zero = (v.end_cause == CAUSE_MSS_READ) ? walk.zero_mss_flag : 1'b0;
        due_verdicts.push_back(v);
        walk = STATE_INIT;
      end
    endfunction

    // Compare one accepted verdict with the oldest one due.
    function void check_verdict(out_word_t got);
      out_word_t want;
      if (due_verdicts.size() == 0) begin
        $error("verdict with none due: mss_zero %0d, end_cause %0d",
               got.mss_zero, got.end_cause);
        errors++;
      end else begin
        want = due_verdicts.pop_front();
        verdicts_seen++;
        cause_hits[want.end_cause]++;
        if (want.mss_zero) zero_mss_seen++;
        if (got.mss_zero !== want.mss_zero) begin
          $error("mss_zero: expected %0d, got %0d", want.mss_zero, got.mss_zero);
          errors++;
        end
        if (got.end_cause !== want.end_cause) begin
          $error("end_cause: expected %0d, got %0d", want.end_cause, got.end_cause);
          errors++;
        end
      end
    endfunction
  endclass

  localparam int LATENCY        = 2;     // acceptance to earliest verdict handshake
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int PHASE_WORDS    = 370;   // random words per idling phase

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  area_verdict_board board;

  logic [7:0] area_bytes[$];  // one options area being built
  int words_sent     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;     // bump to ask the receiver for a long hold-off
  int hold_taken     = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  // Idle settings per phase: none, sender only, receiver only, both.
  int phase_send_idle[4]  = '{0, 50, 0, 30};
  int phase_recv_stall[4] = '{0, 0, 50, 30};

  tcp_option_mss_zero_check_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // Monitor: sample both channels at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_word(in_data);
      if (out_valid && out_ready) board.check_verdict(out_data);
    end
  end

  // Watchdog: a correct block never goes this long without some handshake.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d verdicts still due",
                 quiet_cycles, board.due_verdicts.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a counted hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_req != hold_taken) begin
      hold_taken = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one word and hold it until accepted. Entered and left at a falling edge.
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  // Send area_bytes as one area. Without mark_first the area relies on the
  // walker having reset after the previous verdict; with restarts, an odd
  // first mark lands mid-area and restarts the walk there.
  task automatic send_area(bit mark_first, bit restarts);
    in_word_t w;
    for (int i = 0; i < area_bytes.size(); i++) begin
      w.option_byte   = area_bytes[i];
      w.first_of_area = (i == 0) ? mark_first : (restarts && $urandom_range(49) == 0);
      w.last_of_area  = (i == area_bytes.size() - 1);
      send_word(w);
    end
  endtask

  // Build a random area: mostly well-formed option lists with random content,
  // some with broken options or cut short, and some pure noise.
  task automatic build_area();
    int len;
    area_bytes.delete();
    if ($urandom_range(99) < 10) begin
      len = $urandom_range(1, 12);
      repeat (len) area_bytes.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(7))
          0: area_bytes.push_back(KIND_NOP);
          1: begin
            area_bytes.push_back(KIND_WS);
            area_bytes.push_back(LEN_WS);
            area_bytes.push_back(8'($urandom_range(255)));
          end
          2, 3: begin
            // favor zero halves so zero MSS values come up often
            area_bytes.push_back(KIND_MSS);
            area_bytes.push_back(LEN_MSS);
            area_bytes.push_back($urandom_range(1) ? 8'h00 : 8'($urandom_range(255)));
            area_bytes.push_back($urandom_range(1) ? 8'h00 : 8'($urandom_range(255)));
          end
          4: area_bytes.push_back(KIND_END);
          5: begin
            len = $urandom_range(2, 6);
            area_bytes.push_back(8'($urandom_range(4, 255)));
            area_bytes.push_back(8'(len));
            repeat (len - 2) area_bytes.push_back(8'($urandom_range(255)));
          end
          6: begin
            // any kind with an odd length: zero, one, two or anything
            area_bytes.push_back(8'($urandom_range(255)));
            case ($urandom_range(3))
              0: area_bytes.push_back(8'd0);
              1: area_bytes.push_back(8'd1);
              2: area_bytes.push_back(8'd2);
              default: area_bytes.push_back(8'($urandom_range(255)));
            endcase
          end
          default: begin
            // long skip that often runs past the area's end
            area_bytes.push_back(8'($urandom_range(4, 255)));
            area_bytes.push_back(8'($urandom_range(255)));
            repeat ($urandom_range(6)) area_bytes.push_back(8'($urandom_range(255)));
          end
        endcase
      end
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 3)) area_bytes.push_back(8'($urandom_range(255)));
      if ($urandom_range(4) == 0 && area_bytes.size() > 1) begin
        len = $urandom_range(1, area_bytes.size() - 1);
        while (area_bytes.size() > len) void'(area_bytes.pop_back());
      end
    end
  endtask

  // Pause the sender until every due verdict has come, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.due_verdicts.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  initial begin
    int stop_at;
    board    = new;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed areas, no idling.
    // MSS of zero, then a byte that must be ignored after the stop.
    area_bytes = '{KIND_MSS, LEN_MSS, 8'h00, 8'h00, 8'hFF};
    send_area(1'b1, 1'b0);
    // NOP, window scale, then the largest MSS value.
    area_bytes = '{KIND_NOP, KIND_WS, LEN_WS, 8'd14, KIND_MSS, LEN_MSS, 8'hFF, 8'hFF};
    send_area(1'b1, 1'b0);
    // END alone, with no first mark: the walker restarted after the last verdict.
    area_bytes = '{KIND_END};
    send_area(1'b0, 1'b0);
    // Length one reads as a NOP, window scale of length two has no body,
    // then an MSS kind whose length byte is zero.
    area_bytes = '{8'd5, 8'd1, KIND_WS, 8'd2, KIND_MSS, 8'd0};
    send_area(1'b1, 1'b0);
    // Area ends on an MSS kind byte: exhausted, not truncated.
    area_bytes = '{KIND_MSS};
    send_area(1'b1, 1'b0);
    // MSS cut off after its length, then after its high byte.
    area_bytes = '{KIND_MSS, LEN_MSS};
    send_area(1'b1, 1'b0);
    area_bytes = '{KIND_MSS, LEN_MSS, 8'h00};
    send_area(1'b1, 1'b0);
    // Skip that runs past the end of the area.
    area_bytes = '{8'd9, 8'd255, 8'h55};
    send_area(1'b1, 1'b0);
    drain();

    // Random areas, one idling setting per phase.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = phase_send_idle[ph];
      recv_stall_pct <= phase_recv_stall[ph];
      stop_at = words_sent + PHASE_WORDS;
      while (words_sent < stop_at) begin
        build_area();
        send_area($urandom_range(9) != 0, 1'b1);
      end
      if (ph == 0) begin
        // Hold the receiver off while the sender keeps offering short areas,
        // so verdicts pile up and the block stalls its input.
        hold_req <= hold_req + 1;
        repeat (12) begin
          area_bytes = '{8'($urandom_range(255))};
          send_area(1'b1, 1'b0);
        end
      end
      drain();
    end

    $display("Sent %0d option bytes; checked %0d verdicts, %0d flagging a zero MSS.",
             board.bytes_taken, board.verdicts_seen, board.zero_mss_seen);
    $display("End causes: exhausted %0d, end %0d, zero length %0d, read %0d, truncated %0d.",
             board.cause_hits[0], board.cause_hits[1], board.cause_hits[2],
             board.cause_hits[3], board.cause_hits[4]);
    if (board.errors == 0 && board.due_verdicts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
